// File: rtl/assert_macros.svh
// assertion macros for the rtl of the priority queue, included by sorted_priority_queue
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, switched off while reset is held
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property that also holds during reset
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/spq_pkg.sv
// types, sizes and codes for the sorted priority queue
// no dependencies; imported by spq_cell, sorted_priority_queue and tb_top
package spq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // operation codes carried by func
  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // order_mode values
  localparam logic ORDER_LARGE_FIRST = 1'b0;
  localparam logic ORDER_SMALL_FIRST = 1'b1;

  // one stored entry
  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // control seen by every cell in a cycle
  typedef struct packed {
    logic   shift_en;
    func_t  func;
    logic   order_mode;
    entry_t fresh;
  } cell_cmd_t;

  // per-cell position information derived from the count
  typedef struct packed {
    logic occupied;
    logic at_end;
  } cell_pos_t;

endpackage

// File: rtl/sorted_priority_queue.sv
// Sorted priority queue of up to QUEUE_DEPTH (key, payload) entries, held as a row of
// compare-and-shift cells with the head in cell 0. Each transaction inserts an entry or
// removes the head; its result (head, emptiness, count, status) is registered and presented in the cycle
// after acceptance and held until taken. One transaction is accepted per cycle whenever
// the result register is free or being emptied in the same cycle; the cycle time is set
// by the insertion-point chain that runs through all cells. Among equal keys the newest
// entry comes first. order_mode 0 serves larger keys first, 1 smaller keys first; write
// it only while the queue is idle. There is no clearing pass after reset.
// depends on spq_pkg, spq_cell and assert_macros.svh
`include "assert_macros.svh"

module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_order_mode,
  // input transactions
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_func,
  input  logic [KEY_BITS-1:0]     in_entry_key,
  input  logic [PAYLOAD_BITS-1:0] in_entry_payload,
  // result transactions
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [KEY_BITS-1:0]     out_head_key,
  output logic [PAYLOAD_BITS-1:0] out_head_payload,
  output logic                    out_is_empty,
  output logic [COUNT_BITS-1:0]   out_entry_count,
  output logic [1:0]              out_status
);

  logic                  order_mode_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  status_t               status_r;
  status_t               status_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  in_accept;
  logic                  is_full;
  logic                  is_empty;
  logic                  op_done;
  cell_cmd_t             cmd;
  entry_t                cell_entry [QUEUE_DEPTH];
  logic                  found      [QUEUE_DEPTH+1];

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign is_full  = (count_r == COUNT_BITS'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  // operation goes ahead unless it is an insert when full or a remove when empty
  always_comb begin
    op_done    = 1'b0;
    status_nxt = STAT_OK;
    count_nxt  = count_r;
    if (in_func == FUNC_REMOVE) begin
      if (is_empty) begin
        status_nxt = STAT_EMPTY;
      end else begin
        op_done   = 1'b1;
        count_nxt = count_r - COUNT_BITS'(1);
      end
    end else begin
      if (is_full) begin
        status_nxt = STAT_FULL;
      end else begin
        op_done   = 1'b1;
        count_nxt = count_r + COUNT_BITS'(1);
      end
    end
  end

  // command broadcast to the cell row
  always_comb begin
    cmd.shift_en      = in_accept & op_done;
    cmd.func          = func_t'(in_func);
    cmd.order_mode    = order_mode_r;
    cmd.fresh.key     = in_entry_key;
    cmd.fresh.payload = in_entry_payload;
  end

  assign found[0] = 1'b0;

  // cell row, entries pass to the neighbour on each shift
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_pos_t pos;
    entry_t    left_entry;
    entry_t    right_entry;

    assign pos.occupied = (count_r > COUNT_BITS'(i));
    assign pos.at_end   = (count_r == COUNT_BITS'(i));

    if (i == 0) begin : g_first
      assign left_entry = cmd.fresh;
    end else begin : g_inner_left
      assign left_entry = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner_right
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (pos),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .found_in    (found[i]),
      .found_out   (found[i+1]),
      .entry       (cell_entry[i])
    );
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= ORDER_LARGE_FIRST;
      count_r      <= '0;
      status_r     <= STAT_OK;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        order_mode_r <= cfg_order_mode;
      end
      if (in_accept) begin
        count_r  <= count_nxt;
        status_r <= status_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // head fields from cell 0, the rest from the control registers; queue state only moves on acceptance
  assign out_valid        = out_valid_r;
  assign out_is_empty     = is_empty;
  assign out_entry_count  = count_r;
  assign out_status       = status_r;
  assign out_head_key     = is_empty ? '0 : cell_entry[0].key;
  assign out_head_payload = is_empty ? '0 : cell_entry[0].payload;

  // checks
  `SPQ_ASSERT(a_count_bound, count_r <= COUNT_BITS'(QUEUE_DEPTH), "count beyond depth")
  `SPQ_ASSERT(a_full_drop, (in_accept && in_func == FUNC_INSERT && is_full) |=> (status_r == STAT_FULL && count_r == COUNT_BITS'(QUEUE_DEPTH)), "insert into full queue not dropped")
  `SPQ_ASSERT(a_remove_count, (in_accept && in_func == FUNC_REMOVE && !is_empty) |=> (count_r == COUNT_BITS'($past(count_r) - COUNT_BITS'(1))), "remove did not decrement count")
  `SPQ_ASSERT_ALWAYS(a_no_overwrite, (out_valid_r && out_stall) |-> !in_accept, "accepted while result is stalled")

endmodule

// File: rtl/spq_cell.sv
// one slot of the sorted queue: compares the new key and shifts with its neighbours
// depends on spq_pkg
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  cell_pos_t pos,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  input  logic      found_in,
  output logic      found_out,
  output entry_t    entry
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   ahead;
  logic   hit;

  // new key goes in front of this slot when its priority is not lower
  always_comb begin
    if (cmd.order_mode == ORDER_SMALL_FIRST) begin
      ahead = (cmd.fresh.key <= entry_r.key);
    end else begin
      ahead = (cmd.fresh.key >= entry_r.key);
    end
  end

  // the first free slot always takes the entry if nothing earlier did
  assign hit       = pos.at_end | (pos.occupied & ahead);
  assign found_out = found_in | hit;

  // next contents: shift up on remove, shift down behind the insertion point
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.shift_en) begin
      if (cmd.func == FUNC_REMOVE) begin
        entry_nxt = right_entry;
      end else if (found_in) begin
        entry_nxt = left_entry;
      end else if (hit) begin
        entry_nxt = cmd.fresh;
      end
    end
  end

  // slot storage, contents undefined until written
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for sorted_priority_queue: directed and random insert/remove traffic
// with random idling, a long result hold-off and order_mode changes between phases
// depends on spq_pkg for sizes, operation codes and status codes
import spq_pkg::*;

// one result as seen on the out_ ports
typedef struct packed {
  logic [KEY_BITS-1:0]     head_key;
  logic [PAYLOAD_BITS-1:0] head_payload;
  logic                    is_empty;
  logic [COUNT_BITS-1:0]   entry_count;
  status_t                 status;
} queue_view_t;

// shadow copy of the sorted queue plus the head views still owed by the block
class pq_scoreboard;
  entry_t      shadow_slots[$];
  queue_view_t owed_views[$];
  logic        order_mode;
  int          n_errors;
  int          n_results;
  int          n_inserts;
  int          n_removes;
  int          n_full_drops;
  int          n_empty_removes;
  int          peak_depth;

  function new();
    order_mode = ORDER_LARGE_FIRST;
  endfunction

  function void set_order(logic mode);
    order_mode = mode;
  endfunction

  function int owed_count();
    return owed_views.size();
  endfunction

  // new key goes ahead of a stored one when its priority is not lower
  function bit fresh_outranks(logic [KEY_BITS-1:0] fresh, logic [KEY_BITS-1:0] stored);
    if (order_mode == ORDER_SMALL_FIRST) return fresh <= stored;
    return fresh >= stored;
  endfunction

  // apply one accepted transaction to the shadow queue and note the head it leaves
  function void take_op(func_t op, logic [KEY_BITS-1:0] key, logic [PAYLOAD_BITS-1:0] payload);
    int          pos;
    entry_t      fresh;
    queue_view_t view;
    view.status = STAT_OK;
    if (op == FUNC_INSERT) begin
      n_inserts++;
      if (shadow_slots.size() >= QUEUE_DEPTH) begin
        view.status = STAT_FULL;
        n_full_drops++;
      end else begin
        pos = shadow_slots.size();
        for (int i = 0; i < shadow_slots.size(); i++) begin
          if (fresh_outranks(key, shadow_slots[i].key)) begin
            pos = i;
            break;
          end
        end
        fresh.key     = key;
        fresh.payload = payload;
        shadow_slots.insert(pos, fresh);
      end
    end else begin
      n_removes++;
      if (shadow_slots.size() == 0) begin
        view.status = STAT_EMPTY;
        n_empty_removes++;
      end else begin
        void'(shadow_slots.pop_front());
      end
    end
    if (shadow_slots.size() > peak_depth) peak_depth = shadow_slots.size();
    // empty queue reads back as zero head with the empty flag set
    if (shadow_slots.size() == 0) begin
      view.head_key     = '0;
      view.head_payload = '0;
      view.is_empty     = 1'b1;
    end else begin
      view.head_key     = shadow_slots[0].key;
      view.head_payload = shadow_slots[0].payload;
      view.is_empty     = 1'b0;
    end
    view.entry_count = COUNT_BITS'(shadow_slots.size());
    owed_views.push_back(view);
  endfunction

  // compare one result with the oldest owed view
  function void check_result(queue_view_t got);
    queue_view_t want;
    bit          bad;
    n_results++;
    if (owed_views.size() == 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("%0t unexpected result: key %h payload %h empty %b count %0d status %0d",
                 $realtime, got.head_key, got.head_payload, got.is_empty, got.entry_count,
                 got.status);
      return;
    end
    want = owed_views.pop_front();
    bad = (got.head_key !== want.head_key) || (got.head_payload !== want.head_payload) ||
          (got.is_empty !== want.is_empty) || (got.entry_count !== want.entry_count) ||
          (got.status !== want.status);
    if (bad) begin
      n_errors++;
      if (n_errors <= 10) begin
        $display("%0t result %0d mismatch: want key %h payload %h empty %b count %0d status %0d",
                 $realtime, n_results, want.head_key, want.head_payload, want.is_empty,
                 want.entry_count, want.status);
        $display("%0t result %0d mismatch:  got key %h payload %h empty %b count %0d status %0d",
                 $realtime, n_results, got.head_key, got.head_payload, got.is_empty,
                 got.entry_count, got.status);
      end
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 62;
  localparam int HOLD_CYCLES = 80;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic                    cfg_order_mode;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_func;
  logic [KEY_BITS-1:0]     in_entry_key;
  logic [PAYLOAD_BITS-1:0] in_entry_payload;
  logic                    out_valid;
  logic                    out_stall;
  logic [KEY_BITS-1:0]     out_head_key;
  logic [PAYLOAD_BITS-1:0] out_head_payload;
  logic                    out_is_empty;
  logic [COUNT_BITS-1:0]   out_entry_count;
  logic [1:0]              out_status;

  pq_scoreboard sb = new();

  // random idling on both sides while set
  bit idle_on;
  // cycles the result side still has to hold off
  int hold_left;
  int n_order_writes;

  sorted_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_order_mode   (cfg_order_mode),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_entry_key     (in_entry_key),
    .in_entry_payload (in_entry_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_head_key     (out_head_key),
    .out_head_payload (out_head_payload),
    .out_is_empty     (out_is_empty),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one transaction, optionally after an idle burst, and wait for it to be taken
  task automatic send_op(input func_t op, input logic [KEY_BITS-1:0] key,
                         input logic [PAYLOAD_BITS-1:0] payload);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= op;
    in_entry_key     <= key;
    in_entry_payload <= payload;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_op(op, key, payload);
  endtask

  // drop valid and wait until every owed result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.owed_count() != 0) @(posedge clk);
  endtask

  // write order_mode once the queue has gone quiet
  task automatic write_order(input logic mode);
    drain_results();
    cfg_valid      <= 1'b1;
    cfg_order_mode <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_order(mode);
    n_order_writes++;
    cfg_valid <= 1'b0;
  endtask

  // result side: check taken results and drive stall bursts and the long hold-off
  initial begin : result_side
    queue_view_t got;
    int          burst;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.head_key     = out_head_key;
        got.head_payload = out_head_payload;
        got.is_empty     = out_is_empty;
        got.entry_count  = out_entry_count;
        got.status       = status_t'(out_status);
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 8) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    func_t                   op;
    int                      insert_pct;
    int                      key_shape;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_func          <= FUNC_INSERT;
    in_entry_key     <= '0;
    in_entry_payload <= '0;
    cfg_valid        <= 1'b0;
    cfg_order_mode   <= ORDER_LARGE_FIRST;
    idle_on        = 1'b1;
    hold_left      = 0;
    n_order_writes = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_order(ORDER_LARGE_FIRST);

    // directed: remove on empty, extremes, equal keys, fill to full, dropped insert
    send_op(FUNC_REMOVE, '1, '1);
    send_op(FUNC_INSERT, '0, '0);
    send_op(FUNC_INSERT, '1, '1);
    send_op(FUNC_INSERT, '1, 32'h5A5A5A5A);
    send_op(FUNC_INSERT, 16'h8000, 32'h80000001);
    send_op(FUNC_REMOVE, 16'h1234, 32'hDEADBEEF);
    for (int i = 0; i < 13; i++) begin
      case (i)
        0:       key = '0;
        1:       key = 16'h0001;
        2:       key = 16'hFFFE;
        3:       key = 16'h7FFF;
        default: key = KEY_BITS'($urandom);
      endcase
      send_op(FUNC_INSERT, key, $urandom);
    end
    send_op(FUNC_INSERT, 16'h1234, 32'h0BADF00D);
    send_op(FUNC_REMOVE, '0, '0);
    // flip the order with entries still stored
    write_order(ORDER_SMALL_FIRST);
    send_op(FUNC_INSERT, '0, 32'hFFFF0000);
    send_op(FUNC_INSERT, '1, 32'h0000FFFF);
    send_op(FUNC_REMOVE, '1, '1);

    // random phases: fill-heavy, drain-heavy and mixed, with an order write between them
    for (int phase = 0; phase < N_PHASES; phase++) begin
      write_order(1'($urandom_range(0, 1)));
      idle_on = (phase < N_PHASES - 2) && (phase % 3 != 1);
      case (phase % 4)
        0:       insert_pct = 80;
        1:       insert_pct = 25;
        2:       insert_pct = 55;
        default: insert_pct = 70;
      endcase
      key_shape = $urandom_range(0, 2);
      // long hold-off on the result side while transactions keep being offered
      if (phase == 2) hold_left = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
        case (key_shape)
          0: key = KEY_BITS'($urandom);
          1: key = KEY_BITS'($urandom_range(0, 3));
          default: begin
            case ($urandom_range(0, 3))
              0:       key = '0;
              1:       key = '1;
              2:       key = 16'h8000;
              default: key = KEY_BITS'($urandom);
            endcase
          end
        endcase
        payload = ($urandom_range(0, 9) == 0) ? '1 : $urandom;
        send_op(op, key, payload);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("covered %0d inserts (%0d dropped when full), %0d removes (%0d on empty)",
             sb.n_inserts, sb.n_full_drops, sb.n_removes, sb.n_empty_removes);
    $display("%0d order writes, peak depth %0d, %0d results checked, %0d mismatches",
             n_order_writes, sb.peak_depth, sb.n_results, sb.n_errors);
    if (sb.n_errors == 0 && sb.owed_count() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sv/tb_top.sv
